### rtl/hsv2rgb_pkg.sv
// Constants and types shared by the HSV to RGB pixel pipeline.
`default_nettype none

package hsv2rgb_pkg;

	// Port widths
	localparam int HUE_W   = 17;
	localparam int SAT_W   = 13;
	localparam int VAL_W   = 13;
	localparam int COLOR_W = 8;

	// Internal widths
	localparam int SHF_W   = 17;   // offset hue, 3584..88575
	localparam int SEC_W   = 5;    // coarse sector index, 0..23
	localparam int FR_W    = 12;   // fraction within a sector, 0..3839
	localparam int V255_W  = 21;   // 255 * val
	localparam int SPROD_W = 25;   // sat * fraction
	localparam int NUM_W   = 26;   // signed level numerator
	localparam int PROD_W  = 47;   // 255 * val * level numerator
	localparam int Y_W     = 12;   // scaled level before the divide by 15
	localparam int NLANE   = 4;    // v, p, q, t

	// Hue arithmetic, degrees times 64
	localparam logic signed [HUE_W:0] FULL_TURN  = 18'sd23040;
	localparam logic signed [HUE_W:0] HUE_OFFSET = 18'sd46080;  // twelve sectors
	localparam logic [FR_W-1:0]       SECTOR_SPAN = 12'd3840;

	// x / 15 == (x * 2185) >> 15 for every x below 3840
	localparam logic [11:0] RECIP15       = 12'd2185;
	localparam int          RECIP15_SHIFT = 15;

	// Fixed point: 4096 is 1.0; a level is over 4096 * 3840
	localparam logic [SAT_W-1:0]            ONE_FX    = 13'd4096;
	localparam logic signed [NUM_W-1:0]     LEVEL_DEN = 26'sd15728640;
	localparam logic [14:0]                 Y_LIMIT   = 15'd3840;   // 256 * 15
	localparam logic [COLOR_W-1:0]          COLOR_MAX = 8'd255;

	// Coarse sector codes (floor(offset hue / 3840)) for hue sectors 0..4
	localparam logic [SEC_W-1:0] SEC_0 = 5'd12;
	localparam logic [SEC_W-1:0] SEC_1 = 5'd13;
	localparam logic [SEC_W-1:0] SEC_2 = 5'd14;
	localparam logic [SEC_W-1:0] SEC_3 = 5'd15;
	localparam logic [SEC_W-1:0] SEC_4 = 5'd16;

	// Lane order
	localparam int LANE_V = 0;
	localparam int LANE_P = 1;
	localparam int LANE_Q = 2;
	localparam int LANE_T = 3;

	typedef logic signed [NUM_W-1:0]  level_t;
	typedef logic signed [PROD_W-1:0] wide_prod_t;
	typedef logic [COLOR_W-1:0]       color_t;

endpackage

`default_nettype wire

### rtl/hsv_to_rgb_pixel_core.sv
// HSV to RGB pixel converter: six-stage pipeline, one pixel per clock while out_stall is low.
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  hue[16:0] signed, sat[12:0], val[12:0]
// out      output     out_valid/out_stall  red[7:0], green[7:0], blue[7:0]
//
// Throughput is one transaction per clock while out_stall is low; the stage chain runs
// (wrap, sector divide, s*f multiply, numerators, 255*v*level multiply, divide by 15 + route).
// Reset (arst_n low) clears only the stage valid bits; data registers are not reset.
// Each stage holds while its successor is full and stalled, so bubbles close up and a
// transaction is never dropped or repeated. in_stall is high only when all six stages are full.

module hsv_to_rgb_pixel_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [hsv2rgb_pkg::HUE_W-1:0]  hue,
	input  wire logic [hsv2rgb_pkg::SAT_W-1:0]         sat,
	input  wire logic [hsv2rgb_pkg::VAL_W-1:0]         val,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [hsv2rgb_pkg::COLOR_W-1:0]            red,
	output logic [hsv2rgb_pkg::COLOR_W-1:0]            green,
	output logic [hsv2rgb_pkg::COLOR_W-1:0]            blue
);
	import hsv2rgb_pkg::*;

	// ---------------- stage valid bits and advance chain ----------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	assign adv6 = !vld_s6 || !out_stall;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	// ---------------- stage 1: single hue wrap, offset, 255*v ----------------
	// After one wrap the hue lies in -42496..42495; adding twelve sectors makes it
	// non-negative so the sector split is a plain unsigned divide.
	logic signed [HUE_W:0] h_ext, h_pos, h_wrap, h_shf;
	logic [V255_W-1:0]     v255_c;

	always_comb begin
		h_ext  = {hue[HUE_W-1], hue};
		h_pos  = h_ext[HUE_W] ? (h_ext + FULL_TURN) : h_ext;
		h_wrap = (h_pos >= FULL_TURN) ? (h_pos - FULL_TURN) : h_pos;
		h_shf  = h_wrap + HUE_OFFSET;
		v255_c = (V255_W'(val) << 8) - V255_W'(val);
	end

	logic [SHF_W-1:0]  shf_s1;
	logic [SAT_W-1:0]  sat_s1;
	logic [V255_W-1:0] v255_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			shf_s1  <= h_shf[SHF_W-1:0];
			sat_s1  <= sat;
			v255_s1 <= v255_c;
		end
	end

	// ---------------- stage 2: sector = (shf >> 8) / 15 ----------------
	// 3840 = 256 * 15; the divide by 15 is a reciprocal multiply on 9 bits.
	logic [8:0]  shf_hi;
	logic [20:0] sec_prod;

	assign shf_hi   = shf_s1[SHF_W-1:8];
	assign sec_prod = 21'(shf_hi) * 21'(RECIP15);

	logic [SEC_W-1:0]  sec_s2;
	logic [SHF_W-1:0]  shf_s2;
	logic [SAT_W-1:0]  sat_s2;
	logic [V255_W-1:0] v255_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			sec_s2  <= sec_prod[RECIP15_SHIFT +: SEC_W];
			shf_s2  <= shf_s1;
			sat_s2  <= sat_s1;
			v255_s2 <= v255_s1;
		end
	end

	// ---------------- stage 3: fraction, s*f, s*(1-f), p numerator ----------------
	logic [8:0]             rem9;
	logic [FR_W-1:0]        fr_c, frc_c;
	logic signed [SAT_W:0]  oms;
	level_t                 oms_ext, nump_c;

	always_comb begin
		rem9    = shf_s2[SHF_W-1:8] - ((9'(sec_s2) << 4) - 9'(sec_s2));
		fr_c    = {rem9[3:0], shf_s2[7:0]};
		frc_c   = SECTOR_SPAN - fr_c;
		oms     = $signed({1'b0, ONE_FX}) - $signed({1'b0, sat_s2});
		oms_ext = {{(NUM_W-SAT_W-1){oms[SAT_W]}}, oms};
		nump_c  = (oms_ext <<< 12) - (oms_ext <<< 8);   // (1-s) * 3840
	end

	logic [SPROD_W-1:0] sq_s3, st_s3;
	level_t             nump_s3;
	logic [SEC_W-1:0]   sec_s3;
	logic [V255_W-1:0]  v255_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			sq_s3   <= SPROD_W'(sat_s2) * SPROD_W'(fr_c);
			st_s3   <= SPROD_W'(sat_s2) * SPROD_W'(frc_c);
			nump_s3 <= nump_c;
			sec_s3  <= sec_s2;
			v255_s3 <= v255_s2;
		end
	end

	// ---------------- stage 4: level numerators over 4096*3840 ----------------
	level_t            num_s4 [NLANE];
	logic [SEC_W-1:0]  sec_s4;
	logic [V255_W-1:0] v255_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			num_s4[LANE_V] <= LEVEL_DEN;
			num_s4[LANE_P] <= nump_s3;
			num_s4[LANE_Q] <= LEVEL_DEN - $signed({1'b0, sq_s3});
			num_s4[LANE_T] <= LEVEL_DEN - $signed({1'b0, st_s3});
			sec_s4         <= sec_s3;
			v255_s4        <= v255_s3;
		end
	end

	// ---------------- stage 5: 255 * v * numerator ----------------
	wide_prod_t       prod_s5 [NLANE];
	logic [SEC_W-1:0] sec_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			for (int i = 0; i < NLANE; i++) begin
				prod_s5[i] <= $signed({{(PROD_W-V255_W){1'b0}}, v255_s4}) *
					$signed({{(PROD_W-NUM_W){num_s4[i][NUM_W-1]}}, num_s4[i]});
			end
			sec_s5 <= sec_s4;
		end
	end

	// ---------------- stage 6: /2^32, /15 with clamp, sector routing ----------------
	// Full denominator is 2^32 * 15: drop 32 bits, then a reciprocal divide by 15.
	color_t lane_c [NLANE];

	always_comb begin
		logic [14:0]  y;
		logic [23:0]  yq;
		for (int i = 0; i < NLANE; i++) begin
			y  = prod_s5[i][PROD_W-1:32];
			yq = 24'(y[Y_W-1:0]) * 24'(RECIP15);
			if (prod_s5[i][PROD_W-1] || (prod_s5[i] == '0)) begin
				lane_c[i] = '0;
			end else if (y >= Y_LIMIT) begin
				lane_c[i] = COLOR_MAX;
			end else begin
				lane_c[i] = yq[RECIP15_SHIFT +: COLOR_W];
			end
		end
	end

	color_t red_c, green_c, blue_c;

	always_comb begin
		unique case (sec_s5)
			SEC_0: begin
				red_c = lane_c[LANE_V]; green_c = lane_c[LANE_T]; blue_c = lane_c[LANE_P];
			end
			SEC_1: begin
				red_c = lane_c[LANE_Q]; green_c = lane_c[LANE_V]; blue_c = lane_c[LANE_P];
			end
			SEC_2: begin
				red_c = lane_c[LANE_P]; green_c = lane_c[LANE_V]; blue_c = lane_c[LANE_T];
			end
			SEC_3: begin
				red_c = lane_c[LANE_P]; green_c = lane_c[LANE_Q]; blue_c = lane_c[LANE_V];
			end
			SEC_4: begin
				red_c = lane_c[LANE_T]; green_c = lane_c[LANE_P]; blue_c = lane_c[LANE_V];
			end
			// sector five and any hue left out of range by the single wrap
			default: begin
				red_c = lane_c[LANE_V]; green_c = lane_c[LANE_P]; blue_c = lane_c[LANE_Q];
			end
		endcase
	end

	color_t red_s6, green_s6, blue_s6;

	always_ff @(posedge clk) begin
		if (adv6) begin
			red_s6   <= red_c;
			green_s6 <= green_c;
			blue_s6  <= blue_c;
		end
	end

	assign out_valid = vld_s6;
	assign red       = red_s6;
	assign green     = green_s6;
	assign blue      = blue_s6;

endmodule

`default_nettype wire

### verif/testbench.sv
// Testbench for hsv_to_rgb_pixel_core: predicts each pixel's RGB and checks it against the output stream.
`timescale 1ns / 1ps

module testbench;

	// One HSV pixel as it goes into the block, one RGB pixel as it should come out
	typedef struct packed {
		logic signed [hsv2rgb_pkg::HUE_W-1:0] hue;
		logic [hsv2rgb_pkg::SAT_W-1:0]        sat;
		logic [hsv2rgb_pkg::VAL_W-1:0]        val;
	} hsv_px_t;

	typedef struct packed {
		hsv2rgb_pkg::color_t red;
		hsv2rgb_pkg::color_t green;
		hsv2rgb_pkg::color_t blue;
	} rgb_px_t;

	// Hue in degrees * 64; levels are fractions over UNIT * SPAN
	localparam longint TURN     = 23040;
	localparam longint SPAN     = 3840;
	localparam longint UNIT     = 4096;
	localparam longint FULL_LVL = UNIT * SPAN;
	localparam longint CMAX     = 255;

	localparam int DRAIN_CYCLES  = 20;    // well past the depth of the six-stage pipeline
	localparam int HOLD_CYCLES   = 60;    // long output back-pressure stretch
	localparam int HOLD_PIXELS   = 40;
	localparam int ROUND_PIXELS  = 70;
	localparam int ROUNDS        = 8;
	localparam int MAX_REPORTS   = 40;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	logic signed [hsv2rgb_pkg::HUE_W-1:0] hue;
	logic [hsv2rgb_pkg::SAT_W-1:0]       sat;
	logic [hsv2rgb_pkg::VAL_W-1:0]       val;
	logic                                out_valid;
	logic                                out_stall;
	hsv2rgb_pkg::color_t                 red;
	hsv2rgb_pkg::color_t                 green;
	hsv2rgb_pkg::color_t                 blue;

	hsv_px_t pixel_backlog[$];   // pixels waiting to be offered
	rgb_px_t rgb_due[$];         // colors owed by the block, oldest first
	hsv_px_t next_px;
	rgb_px_t got_px;
	rgb_px_t want_px;

	int tx_gap_pct;              // chance per cycle that the sender idles
	int rx_stall_pct;            // chance per cycle that the receiver stalls
	logic hold_rx;               // forced receiver stall for the back-pressure test
	int mismatches;

	hsv_to_rgb_pixel_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.hue       (hue),
		.sat       (sat),
		.val       (val),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	always #5 clk = ~clk;

	// floor(255 * v * lvl / (4096 * 4096 * 3840)), clamped to 0..255.
	// Worst case magnitude is near 3.3e13, well inside 64 bits.
	function automatic hsv2rgb_pkg::color_t level_to_color(longint v, longint lvl);
		longint prod;
		longint q;
		prod = CMAX * v * lvl;
		if (prod <= 0)
			return '0;
		q = prod / (UNIT * FULL_LVL);
		if (q > CMAX)
			q = CMAX;
		return hsv2rgb_pkg::color_t'(q);
	endfunction

	// Golden HSV -> RGB for one pixel
	function automatic rgb_px_t hsv_to_rgb(hsv_px_t px);
		longint h, s, v, offs, sector, frac;
		hsv2rgb_pkg::color_t cv, cp, cq, ct;
		rgb_px_t c;
		h = longint'($signed(px.hue));
		s = longint'(px.sat);
		v = longint'(px.val);
		// single wrap only; a hue far outside one turn stays out of range
		if (h < 0)
			h += TURN;
		if (h >= TURN)
			h -= TURN;
		// floor division by one sector; the offset keeps the dividend positive
		offs   = h + 12 * SPAN;
		sector = offs / SPAN - 12;
		frac   = offs % SPAN;
		cv = level_to_color(v, FULL_LVL);
		cp = level_to_color(v, (UNIT - s) * SPAN);
		cq = level_to_color(v, FULL_LVL - s * frac);
		ct = level_to_color(v, FULL_LVL - s * (SPAN - frac));
		case (sector)
			0: c = '{cv, ct, cp};
			1: c = '{cq, cv, cp};
			2: c = '{cp, cv, ct};
			3: c = '{cp, cq, cv};
			4: c = '{ct, cp, cv};
			// sector 5, and any sector a badly out-of-range hue lands in
			default: c = '{cv, cp, cq};
		endcase
		return c;
	endfunction

	task automatic queue_pixel(int h, int s, int v);
		hsv_px_t px;
		px.hue = h[hsv2rgb_pkg::HUE_W-1:0];
		px.sat = s[hsv2rgb_pkg::SAT_W-1:0];
		px.val = v[hsv2rgb_pkg::VAL_W-1:0];
		pixel_backlog.push_back(px);
	endtask

	// Mostly nominal pixels, some on sector edges, some with raw full-width bits
	function automatic hsv_px_t random_pixel();
		hsv_px_t px;
		int pick;
		int h, s, v;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			h = int'($urandom_range(0, 69119)) - 23040;
			s = int'($urandom_range(0, 4096));
			v = int'($urandom_range(0, 4096));
		end else if (pick < 85) begin
			h = (int'($urandom_range(0, 17)) - 6) * 3840 + int'($urandom_range(0, 4)) - 2;
			s = $urandom_range(0, 1) ? 4096 : int'($urandom_range(0, 4096));
			v = $urandom_range(0, 1) ? 4096 : int'($urandom_range(0, 4096));
		end else begin
			h = int'($urandom());
			s = int'($urandom());
			v = int'($urandom());
		end
		px.hue = h[hsv2rgb_pkg::HUE_W-1:0];
		px.sat = s[hsv2rgb_pkg::SAT_W-1:0];
		px.val = v[hsv2rgb_pkg::VAL_W-1:0];
		return px;
	endfunction

	task automatic note_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] ERROR: %s", $time, what);
	endtask

	// Driver: records each accepted transaction's prediction, then offers the next
	// pixel whenever the current one is gone or none is up. Payload holds while stalled.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				rgb_due.push_back(hsv_to_rgb('{hue, sat, val}));
			if (!in_valid || !in_stall) begin
				if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
					next_px = pixel_backlog.pop_front();
					in_valid <= 1'b1;
					hue      <= next_px.hue;
					sat      <= next_px.sat;
					val      <= next_px.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every accepted result must match the oldest prediction, field by field
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got_px = '{red, green, blue};
				if (rgb_due.size() == 0) begin
					note_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
						red, green, blue));
				end else begin
					want_px = rgb_due.pop_front();
					if (got_px.red !== want_px.red)
						note_mismatch($sformatf("red got %0d want %0d",
							got_px.red, want_px.red));
					if (got_px.green !== want_px.green)
						note_mismatch($sformatf("green got %0d want %0d",
							got_px.green, want_px.green));
					if (got_px.blue !== want_px.blue)
						note_mismatch($sformatf("blue got %0d want %0d",
							got_px.blue, want_px.blue));
				end
			end
			out_stall <= hold_rx || ($urandom_range(0, 99) < rx_stall_pct);
		end
	end

	// Stimulus sequencing. All of it runs on the falling edge so that settings
	// and backlog changes never race the rising-edge driver and monitor.
	initial begin
		int gap_tbl[4];
		int stall_tbl[4];
		int mode;
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		hue          = '0;
		sat          = '0;
		val          = '0;
		out_stall    = 1'b0;
		hold_rx      = 1'b0;
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		mismatches   = 0;
		gap_tbl      = '{0, 49, 0, 35};
		stall_tbl    = '{0, 0, 49, 35};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: primaries and sector edges at full saturation/value, the
		// wrap limits, hues still out of range after one wrap, gray and black,
		// and saturation/value above 1.0.
		queue_pixel(0, 4096, 4096);
		queue_pixel(-23040, 4096, 4096);
		queue_pixel(23039, 4096, 4096);
		queue_pixel(3839, 4096, 4096);
		queue_pixel(3840, 4096, 4096);
		queue_pixel(7680, 4096, 4096);
		queue_pixel(11520, 4096, 4096);
		queue_pixel(15360, 4096, 4096);
		queue_pixel(19200, 4096, 4096);
		queue_pixel(1920, 4096, 4096);
		queue_pixel(23040, 4096, 4096);
		queue_pixel(46079, 4096, 4096);
		queue_pixel(-1, 2048, 4096);
		queue_pixel(-65536, 4096, 4096);
		queue_pixel(65535, 4096, 4096);
		queue_pixel(-23041, 3000, 4000);
		queue_pixel(46080, 3000, 4000);
		queue_pixel(-30000, 1234, 2345);
		queue_pixel(5000, 0, 4096);
		queue_pixel(5000, 4096, 0);
		queue_pixel(5000, 8191, 4096);
		queue_pixel(5000, 2048, 8191);
		queue_pixel(12345, 8191, 8191);
		while (in_valid || pixel_backlog.size() != 0 || rgb_due.size() != 0)
			@(negedge clk);

		// Back-pressure: the receiver holds off for a long stretch while the
		// sender streams, so all six stages fill and in_stall must rise.
		fork
			begin
				hold_rx = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rx = 1'b0;
			end
		join_none
		repeat (HOLD_PIXELS)
			pixel_backlog.push_back(random_pixel());
		while (hold_rx || in_valid || pixel_backlog.size() != 0 || rgb_due.size() != 0)
			@(negedge clk);

		// Random rounds cycling through the idle/stall mixes; each round drains
		// fully, so the sender also pauses until every result is back.
		for (int r = 0; r < ROUNDS; r++) begin
			mode         = r % 4;
			tx_gap_pct   = gap_tbl[mode];
			rx_stall_pct = stall_tbl[mode];
			repeat (ROUND_PIXELS)
				pixel_backlog.push_back(random_pixel());
			while (in_valid || pixel_backlog.size() != 0 || rgb_due.size() != 0)
				@(negedge clk);
		end

		// let any stray output show up before the verdict
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (rgb_due.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", rgb_due.size()));
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run (about 650 pixels at heavy stalls)
	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
